/* src/assert_macros.svh */
// assertion macros shared by the rds uecp parser modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* src/rds_pkg.sv */
// package for the rds uecp frame parser: types, constants, crc step
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rds_pkg;

  localparam int TEXT_BYTES_DEF = 64;

  localparam logic [7:0] BYTE_SYNC  = 8'hFF;
  localparam logic [7:0] BYTE_START = 8'hFE;
  localparam logic [7:0] BYTE_ESC   = 8'hFD;
  localparam logic [7:0] MEC_RT     = 8'h0A;
  localparam logic [7:0] MEC_RTP    = 8'h46;
  localparam logic [7:0] MEC_RASS   = 8'hDA;
  localparam logic [7:0] AID_HI     = 8'h4B;
  localparam logic [7:0] AID_LO     = 8'hD7;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  typedef enum logic [2:0] {
    KIND_TEXT      = 3'd0,
    KIND_TEXT_ERR  = 3'd1,
    KIND_RTP       = 3'd2,
    KIND_RTP_ERR   = 3'd3,
    KIND_RASS_OK   = 3'd4,
    KIND_RASS_ERR  = 3'd5
  } kind_t;

  // frame parser states
  typedef enum logic [5:0] {
    PS_IDLE        = 6'd0,
    PS_ADDR1       = 6'd1,
    PS_ADDR2       = 6'd2,
    PS_SEQ         = 6'd3,
    PS_LEN         = 6'd4,
    PS_MEC         = 6'd5,
    PS_RT_DSN      = 6'd6,
    PS_RT_PSN      = 6'd7,
    PS_RT_MEL      = 6'd8,
    PS_RT_STATUS   = 6'd9,
    PS_RT_TEXT     = 6'd10,
    PS_RT_CRC_HI   = 6'd11,
    PS_RT_CRC_LO   = 6'd12,
    PS_RASS_MEL    = 6'd26,
    PS_RASS_H1     = 6'd27,
    PS_RASS_H2     = 6'd28,
    PS_RASS_PN2    = 6'd29,
    PS_RASS_PN1    = 6'd30,
    PS_RASS_PN0    = 6'd31,
    PS_RASS_PC2    = 6'd32,
    PS_RASS_PC1    = 6'd33,
    PS_RASS_PC0    = 6'd34,
    PS_RASS_DATA   = 6'd35,
    PS_RASS_CRC_HI = 6'd36,
    PS_RASS_CRC_LO = 6'd37,
    PS_RTP_MEL     = 6'd38,
    PS_RTP_AID_HI  = 6'd39,
    PS_RTP_AID_LO  = 6'd40,
    PS_RTP_CB      = 6'd41,
    PS_RTP_TAG0    = 6'd42,
    PS_RTP_TAG1    = 6'd43,
    PS_RTP_TAG2    = 6'd44,
    PS_RTP_TAG3    = 6'd45,
    PS_RTP_TAG4    = 6'd46,
    PS_RTP_CRC_HI  = 6'd47,
    PS_RTP_CRC_LO  = 6'd48
  } ps_t;

  // event handed from front to back
  typedef enum logic [1:0] {
    EV_TEXT_OK  = 2'd0,
    EV_TEXT_ERR = 2'd1,
    EV_RTP      = 2'd2
  } ev_t;

  typedef struct packed {
    ev_t         ev;
    logic [6:0]  count;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_TRIM = 2'd1,
    BK_EMIT = 2'd2
  } bk_state_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    logic [7:0]  lo;
    x  = {crc[7:0], crc[15:8]};
    x  = x ^ {8'h00, b};
    x  = x ^ {12'h000, x[7:4]};
    lo = x[7:0];
    x  = x ^ {lo[3:0], 12'h000} ^ {3'b000, lo, 5'b00000};
    return x;
  endfunction

endpackage
`default_nettype wire

/* src/rds_front.sv */
// front: unstuffing, frame state machine, crc check, text store writes
// depends on rds_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rds_front #(
  parameter int TEXT_BYTES = rds_pkg::TEXT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  output logic             in_ready,
  // text store write port
  output logic             wr_en,
  output logic [$clog2(TEXT_BYTES)-1:0] wr_addr,
  output logic [7:0]       wr_data,
  // job to back part
  output logic             job_valid,
  input  wire logic        job_ready,
  output rds_pkg::job_t    job,
  // direct results (rass, rt+ tags, rt+ error): single-shot
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [2:0]       res_kind,
  output logic             res_last,
  output logic [23:0]      res_pn,
  output logic [39:0]      res_tags
);
  localparam int AW = $clog2(TEXT_BYTES);

  rds_pkg::ps_t st, st_next, s0;
  logic        esc;
  logic [15:0] crc;
  logic [15:0] rcrc;
  logic [7:0]  fli;
  logic [7:0]  rem;
  logic [6:0]  widx;
  logic        tvalid;
  logic [7:0]  tagb [5];
  logic [23:0] pn, pc;

  logic        acc, take;
  logic [7:0]  c;
  logic [15:0] crc_base, crc_new;
  logic        crc_upd, good;
  logic        busy;

  // back part idle is required so the text store is not rewritten mid-run
  assign busy     = job_valid || res_valid;
  assign in_ready = !busy && job_ready;
  assign acc      = in_valid && in_ready;

  assign s0   = (in_byte == rds_pkg::BYTE_SYNC) ? rds_pkg::PS_IDLE : st;
  assign take = !(in_byte == rds_pkg::BYTE_ESC && !esc && s0 != rds_pkg::PS_IDLE);

  always_comb begin
    c = in_byte;
    if (esc) begin
      case (in_byte)
        8'h00:   c = 8'hFD;
        8'h01:   c = 8'hFE;
        8'h02:   c = 8'hFF;
        default: c = in_byte;
      endcase
    end
  end

  assign crc_base = (s0 == rds_pkg::PS_ADDR1) ? 16'hFFFF : crc;
  assign crc_upd  = (s0 >= rds_pkg::PS_ADDR1 && s0 < rds_pkg::PS_RT_CRC_HI)
                    || (s0 >= rds_pkg::PS_RASS_MEL && s0 < rds_pkg::PS_RASS_CRC_HI)
                    || (s0 >= rds_pkg::PS_RTP_MEL && s0 < rds_pkg::PS_RTP_CRC_HI);
  assign crc_new  = crc_upd ? rds_pkg::crc_step(crc_base, c) : crc_base;
  assign good     = ({rcrc[15:8], c} == ~crc);

  always_comb begin
    st_next = rds_pkg::PS_IDLE;
    case (s0)
      rds_pkg::PS_IDLE:
        st_next = (c == rds_pkg::BYTE_START) ? rds_pkg::PS_ADDR1 : rds_pkg::PS_IDLE;
      rds_pkg::PS_ADDR1, rds_pkg::PS_ADDR2, rds_pkg::PS_SEQ, rds_pkg::PS_RT_DSN,
      rds_pkg::PS_RT_PSN, rds_pkg::PS_RASS_H1, rds_pkg::PS_RASS_H2, rds_pkg::PS_RTP_CB,
      rds_pkg::PS_RASS_PN2, rds_pkg::PS_RASS_PN1, rds_pkg::PS_RASS_PN0,
      rds_pkg::PS_RASS_PC2, rds_pkg::PS_RASS_PC1, rds_pkg::PS_RASS_PC0,
      rds_pkg::PS_RT_CRC_HI, rds_pkg::PS_RASS_CRC_HI, rds_pkg::PS_RTP_CRC_HI,
      rds_pkg::PS_RTP_TAG0, rds_pkg::PS_RTP_TAG1, rds_pkg::PS_RTP_TAG2,
      rds_pkg::PS_RTP_TAG3, rds_pkg::PS_RTP_TAG4:
        st_next = rds_pkg::ps_t'(s0 + 6'd1);
      rds_pkg::PS_LEN:  st_next = rds_pkg::PS_MEC;
      rds_pkg::PS_MEC: begin
        if (c == rds_pkg::MEC_RT) st_next = rds_pkg::PS_RT_DSN;
        else if (c == rds_pkg::MEC_RTP) st_next = rds_pkg::PS_RTP_MEL;
        else if (c == rds_pkg::MEC_RASS) st_next = rds_pkg::PS_RASS_MEL;
        else st_next = rds_pkg::PS_IDLE;
      end
      rds_pkg::PS_RT_MEL: begin
        if (c == 8'd0 || {1'b0, c} > 9'(TEXT_BYTES + 1) || ({1'b0, c} + 9'd4) > {1'b0, fli})
          st_next = rds_pkg::PS_IDLE;
        else st_next = rds_pkg::PS_RT_STATUS;
      end
      rds_pkg::PS_RT_STATUS:
        st_next = (rem == 8'd0) ? rds_pkg::PS_RT_CRC_HI : rds_pkg::PS_RT_TEXT;
      rds_pkg::PS_RT_TEXT:
        st_next = (rem <= 8'd1) ? rds_pkg::PS_RT_CRC_HI : rds_pkg::PS_RT_TEXT;
      rds_pkg::PS_RASS_MEL:
        st_next = (c < 8'd9) ? rds_pkg::PS_IDLE : rds_pkg::PS_RASS_H1;
      rds_pkg::PS_RASS_DATA:
        st_next = (rem == 8'd0) ? rds_pkg::PS_RASS_CRC_HI : rds_pkg::PS_RASS_DATA;
      rds_pkg::PS_RTP_MEL:
        st_next = (fli == 8'd10 && c == 8'd8) ? rds_pkg::PS_RTP_AID_HI : rds_pkg::PS_IDLE;
      rds_pkg::PS_RTP_AID_HI:
        st_next = (c == rds_pkg::AID_HI) ? rds_pkg::PS_RTP_AID_LO : rds_pkg::PS_IDLE;
      rds_pkg::PS_RTP_AID_LO:
        st_next = (c == rds_pkg::AID_LO) ? rds_pkg::PS_RTP_CB : rds_pkg::PS_IDLE;
      default: st_next = rds_pkg::PS_IDLE;
    endcase
  end

  assign wr_en   = acc && take && s0 == rds_pkg::PS_RT_TEXT && widx < 7'(TEXT_BYTES);
  assign wr_addr = widx[AW-1:0];
  assign wr_data = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rds_pkg::PS_IDLE; esc <= 1'b0; crc <= 16'hFFFF; rcrc <= 16'h0; fli <= 8'h0;
      rem <= 8'h0; widx <= 7'h0; tvalid <= 1'b0; pn <= 24'h0; pc <= 24'h0;
      job_valid <= 1'b0; res_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (acc) begin
        if (!take) begin
          st  <= s0;
          esc <= 1'b1;
        end else begin
          esc <= 1'b0;
          st  <= st_next;
          crc <= crc_new;
          case (s0)
            rds_pkg::PS_LEN:  fli <= c;
            rds_pkg::PS_RT_MEL: begin
              rem  <= c - 8'd1;
              widx <= 7'd0;
            end
            rds_pkg::PS_RT_TEXT: begin
              if (widx < 7'(TEXT_BYTES)) widx <= widx + 7'd1;
              if (rem != 8'd0) rem <= rem - 8'd1;
            end
            rds_pkg::PS_RT_CRC_HI, rds_pkg::PS_RASS_CRC_HI, rds_pkg::PS_RTP_CRC_HI:
              rcrc <= {c, 8'h00};
            rds_pkg::PS_RT_CRC_LO: begin
              rcrc      <= {rcrc[15:8], c};
              tvalid    <= good;
              job_valid <= 1'b1;
              job.ev    <= good ? rds_pkg::EV_TEXT_OK : rds_pkg::EV_TEXT_ERR;
              job.count <= widx;
            end
            rds_pkg::PS_RASS_MEL: rem <= c - 8'd9;
            rds_pkg::PS_RASS_PN2: pn[23:16] <= c;
            rds_pkg::PS_RASS_PN1: pn[15:8]  <= c;
            rds_pkg::PS_RASS_PN0: pn[7:0]   <= c;
            rds_pkg::PS_RASS_PC2: pc[23:16] <= c;
            rds_pkg::PS_RASS_PC1: pc[15:8]  <= c;
            rds_pkg::PS_RASS_PC0: pc[7:0]   <= c;
            rds_pkg::PS_RASS_DATA: if (rem != 8'd0) rem <= rem - 8'd1;
            rds_pkg::PS_RASS_CRC_LO: begin
              rcrc      <= {rcrc[15:8], c};
              res_valid <= 1'b1;
              res_kind  <= good ? 3'(rds_pkg::KIND_RASS_OK) : 3'(rds_pkg::KIND_RASS_ERR);
              res_last  <= (pn == pc);
              res_pn    <= pn;
              res_tags  <= '0;
            end
            rds_pkg::PS_RTP_TAG0: tagb[0] <= c;
            rds_pkg::PS_RTP_TAG1: tagb[1] <= c;
            rds_pkg::PS_RTP_TAG2: tagb[2] <= c;
            rds_pkg::PS_RTP_TAG3: tagb[3] <= c;
            rds_pkg::PS_RTP_TAG4: tagb[4] <= c;
            rds_pkg::PS_RTP_CRC_LO: begin
              rcrc <= {rcrc[15:8], c};
              res_last <= 1'b0;
              res_pn   <= '0;
              if (!good) begin
                res_valid <= 1'b1;
                res_kind  <= 3'(rds_pkg::KIND_RTP_ERR);
                res_tags  <= '0;
              end else if (tvalid) begin
                res_valid <= 1'b1;
                res_kind  <= 3'(rds_pkg::KIND_RTP);
                res_tags  <= {tagb[4][4:0], tagb[3][2:0], tagb[4][7:5],
                              tagb[2][0], tagb[3][7:3], tagb[2][6:1],
                              tagb[1][4:0], tagb[2][7], tagb[0][2:0], tagb[1][7:5],
                              tagb[0][3], tagb[0][7:4]};
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_one_out, clk, rst, !(job_valid && res_valid), "front: two results pending")
  `ASSERT_IMPLIES(a_widx, clk, rst, 1'b1, widx <= 7'(TEXT_BYTES), "front: write index overflow")
  `ASSERT_IMPLIES(a_no_acc, clk, rst, busy, !in_ready, "front: accepted while busy")
endmodule
`default_nettype wire

/* src/rds_back.sv */
// back: text store, trailing space trim, text run and text error emission
// depends on rds_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rds_back #(
  parameter int TEXT_BYTES = rds_pkg::TEXT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [$clog2(TEXT_BYTES)-1:0] wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  rds_pkg::job_t    job,
  output logic             o_valid,
  input  wire logic        o_ready,
  output logic [2:0]       o_kind,
  output logic [7:0]       o_byte,
  output logic             o_last
);
  localparam int AW = $clog2(TEXT_BYTES);

  logic [7:0] mem [TEXT_BYTES];
  rds_pkg::bk_state_t st, st_next;
  logic [6:0] cnt;     // characters still considered
  logic [6:0] idx;
  logic [6:0] rd_addr;
  logic [7:0] rd_data;
  logic       rd_ok;
  logic       ld;

  // entries at or above the last write count are not cleared; reads are registered
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr[AW-1:0]];
  end

  assign ld = st == rds_pkg::BK_EMIT && (!o_valid || o_ready) && idx < cnt && !rd_ok;

  always_comb begin
    rd_addr = idx;
    if (st == rds_pkg::BK_TRIM) rd_addr = cnt - 7'd1;
  end

  always_comb begin
    st_next = st;
    case (st)
      rds_pkg::BK_IDLE: if (job_valid && !o_valid) begin
        if (job.ev == rds_pkg::EV_TEXT_OK && job.count > 7'd1) st_next = rds_pkg::BK_TRIM;
        else if (job.ev == rds_pkg::EV_TEXT_OK && job.count == 7'd1)
          st_next = rds_pkg::BK_EMIT;
      end
      rds_pkg::BK_TRIM: if (rd_ok && (rd_data != rds_pkg::BYTE_SPACE || cnt == 7'd1))
        st_next = rds_pkg::BK_EMIT;
      rds_pkg::BK_EMIT: if (idx == cnt && !rd_ok && (!o_valid || o_ready))
        st_next = rds_pkg::BK_IDLE;
      default: st_next = rds_pkg::BK_IDLE;
    endcase
  end

  assign job_ready = st == rds_pkg::BK_IDLE && !o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rds_pkg::BK_IDLE; o_valid <= 1'b0; rd_ok <= 1'b0; cnt <= '0; idx <= '0;
    end else begin
      st <= st_next;
      if (o_valid && o_ready && !(st == rds_pkg::BK_EMIT && rd_ok)) o_valid <= 1'b0;
      case (st)
        rds_pkg::BK_IDLE: if (job_valid && !o_valid) begin
          idx   <= '0;
          rd_ok <= 1'b0;
          cnt   <= job.count;
          if (job.ev == rds_pkg::EV_TEXT_ERR) begin
            o_valid <= 1'b1; o_kind <= 3'(rds_pkg::KIND_TEXT_ERR);
            o_byte <= 8'h0; o_last <= 1'b0;
          end else if (job.ev == rds_pkg::EV_TEXT_OK && job.count == 7'd0) begin
            o_valid <= 1'b1; o_kind <= 3'(rds_pkg::KIND_TEXT);
            o_byte <= 8'h0; o_last <= 1'b1;
          end
        end
        rds_pkg::BK_TRIM: begin
          if (!rd_ok) rd_ok <= 1'b1;
          else if (rd_data == rds_pkg::BYTE_SPACE && cnt > 7'd1) begin
            cnt   <= cnt - 7'd1;
            rd_ok <= 1'b0;
          end else rd_ok <= 1'b0;
        end
        rds_pkg::BK_EMIT: begin
          if (ld) rd_ok <= 1'b1;
          if (rd_ok && (!o_valid || o_ready)) begin
            o_valid <= 1'b1; o_kind <= 3'(rds_pkg::KIND_TEXT);
            o_byte  <= rd_data; o_last <= (idx + 7'd1 == cnt);
            idx     <= idx + 7'd1;
            rd_ok   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_idx, clk, rst, 1'b1, idx <= cnt, "back: index past count")
  `ASSERT_IMPLIES(a_cnt, clk, rst, 1'b1, cnt <= 7'(TEXT_BYTES), "back: count too large")
  `ASSERT_IMPLIES(a_trim, clk, rst, st == rds_pkg::BK_TRIM, cnt >= 7'd1, "back: trim empty")
endmodule
`default_nettype wire

/* src/rds_uecp_frame_parser.sv */
// top level of the rds uecp frame parser: front, back, output merge
// depends on rds_pkg, rds_front, rds_back
`timescale 1ns / 1ps
`default_nettype none
// usage:
// s_axis carries one ancillary byte per transfer in tdata[7:0].
// m_axis carries one result per transfer; tdata fields from bit 0:
//   text_byte(8) last(1) toggle_bits(4) running_bit(1) tag1_type(6)
//   tag1_start(6) tag1_length(6) tag2_type(6) tag2_start(6) tag2_length(5)
//   packet_number(24), zero padded; tuser holds kind(3).
// the front takes one byte per cycle while no frame result is pending and
// no text run is being emitted; the final crc byte of a frame produces its
// results. rass and rt+ results appear on the cycle after that byte. a text
// run first trims trailing spaces, reading the text store from its end,
// then emits the kept characters in order through the registered read
// port of the text store; input stalls meanwhile.
// reset (rst, synchronous) returns the parser to idle and drops held text.
// when m_axis_tready is low results are held and the input stalls once
// the single front output slot is full.
module rds_uecp_frame_parser #(
  parameter int TEXT_BYTES = rds_pkg::TEXT_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [79:0]       m_axis_tdata,   // see header for field list
  output logic [2:0]        m_axis_tuser    // kind
);
  localparam int AW = $clog2(TEXT_BYTES);

  logic wr_en; logic [AW-1:0] wr_addr; logic [7:0] wr_data;
  logic job_valid, job_ready; rds_pkg::job_t job;
  logic rv, rr; logic [2:0] rk; logic rl; logic [23:0] rpn; logic [39:0] rtags;
  logic bv, br; logic [2:0] bk; logic [7:0] bb; logic bl;

  rds_front #(.TEXT_BYTES(TEXT_BYTES)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_ready(s_axis_tready),
    .wr_en, .wr_addr, .wr_data, .job_valid, .job_ready, .job,
    .res_valid(rv), .res_ready(rr), .res_kind(rk), .res_last(rl), .res_pn(rpn),
    .res_tags(rtags));

  rds_back #(.TEXT_BYTES(TEXT_BYTES)) u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .job_valid, .job_ready, .job,
    .o_valid(bv), .o_ready(br), .o_kind(bk), .o_byte(bb), .o_last(bl));

  assign m_axis_tvalid = bv || rv;
  assign br = m_axis_tready;
  assign rr = m_axis_tready && !bv;
  always_comb begin
    if (bv) begin
      m_axis_tuser = bk;
      m_axis_tdata = {71'd0, bl, bb};
    end else begin
      m_axis_tuser = rk;
      m_axis_tdata = {7'd0, rpn, rtags, rl, 8'd0};
    end
  end
endmodule
`default_nettype wire

/* tb/rds_uecp_frame_parser_tb.sv */
// testbench for rds_uecp_frame_parser: escaped byte frames in, checked results out
// builds radiotext, rt+ and rass frames with crc plus bad length and noise bytes, predicts every result in-line
// depends on rds_pkg and the rds_uecp_frame_parser rtl
`timescale 1ns / 1ps
`default_nettype none
module rds_uecp_frame_parser_tb;

  localparam int TXT = 64;
  typedef struct {
    logic [2:0]  kind;
    logic [79:0] data;
  } parse_result_t;

  // directed frame table row
  typedef enum int {FR_TEXT, FR_SPACES, FR_RTP, FR_RASS, FR_BADLEN, FR_NOISE} frame_kind_t;
  typedef struct {
    frame_kind_t fk;
    int          size;
    bit          bad_crc;
  } frame_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  rds_uecp_frame_parser u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // predicted parser state
  int          ps;
  bit          esc;
  logic [15:0] crc_acc, crc_rx;
  logic [7:0]  len_info, remain;
  logic [6:0]  wr_idx;
  logic [7:0]  txt_mem [TXT];
  bit          txt_ok;
  logic [7:0]  tags [5];
  logic [23:0] pkt_num, pkt_cnt;

  parse_result_t expected_results[$];
  logic [7:0]    byte_q[$];
  logic [15:0]   build_crc;
  int            errors = 0;
  bit            burst = 0;

  function automatic logic [15:0] ccitt(input logic [15:0] c, input logic [7:0] d);
    logic [7:0] t;
    t = c[15:8] ^ d;
    t = t ^ (t >> 4);
    return {c[7:0], 8'h00} ^ ({8'h00, t} << 12) ^ ({8'h00, t} << 5) ^ {8'h00, t};
  endfunction

  task automatic push_result(input logic [2:0] k, input logic [79:0] d);
    parse_result_t r;
    r.kind = k;
    r.data = d;
    expected_results.push_back(r);
  endtask

  task automatic predict_byte(input logic [7:0] raw);
    logic [7:0]  c;
    logic [79:0] d;
    int          s, cnt;
    c = raw;
    if (c == rds_pkg::BYTE_SYNC) ps = 0;
    if (c == rds_pkg::BYTE_ESC && !esc && ps > 0) begin
      esc = 1;
      return;
    end
    if (esc) begin
      esc = 0;
      if (c == 8'h00) c = 8'hFD;
      else if (c == 8'h01) c = 8'hFE;
      else if (c == 8'h02) c = 8'hFF;
    end
    s = ps;
    if (s == 1) crc_acc = 16'hFFFF;
    if ((s >= 1 && s < 11) || (s >= 26 && s < 36) || (s >= 38 && s < 47))
      crc_acc = ccitt(crc_acc, c);
    case (s)
      0: if (c == rds_pkg::BYTE_START) ps = 1;
      1, 2, 3, 6, 7, 27, 28, 41: ps = s + 1;
      4: begin
        len_info = c;
        ps = 5;
      end
      5: ps = (c == rds_pkg::MEC_RT) ? 6 : (c == rds_pkg::MEC_RTP) ? 38
            : (c == rds_pkg::MEC_RASS) ? 26 : 0;
      8: begin
        if (c == 0 || c > TXT + 1 || int'(c) + 4 > int'(len_info)) ps = 0;
        else begin
          remain = c - 8'd1;
          wr_idx = 0;
          foreach (txt_mem[i]) txt_mem[i] = 0;
          ps = 9;
        end
      end
      9: ps = (remain == 0) ? 11 : 10;
      10: begin
        if (wr_idx < TXT) begin
          txt_mem[wr_idx] = c;
          wr_idx++;
        end
        if (remain > 0) remain--;
        ps = (remain == 0) ? 11 : 10;
      end
      11, 36, 47: begin
        crc_rx = {c, 8'h00};
        ps = s + 1;
      end
      12: begin
        crc_rx[7:0] = c;
        ps = 0;
        if (crc_rx == ~crc_acc) begin
          cnt = wr_idx;
          if (cnt > TXT) cnt = TXT;
          while (cnt > 1 && txt_mem[cnt-1] == rds_pkg::BYTE_SPACE) begin
            txt_mem[cnt-1] = 0;
            cnt--;
          end
          txt_ok = 1;
          if (cnt == 0) push_result(rds_pkg::KIND_TEXT, 80'h100);
          else
            for (int i = 0; i < cnt; i++) begin
              d = '0;
              d[7:0] = txt_mem[i];
              d[8] = (i + 1 == cnt);
              push_result(rds_pkg::KIND_TEXT, d);
            end
        end else begin
          txt_ok = 0;
          push_result(rds_pkg::KIND_TEXT_ERR, '0);
        end
      end
      26: begin
        if (c < 9) ps = 0;
        else begin
          remain = c - 8'd9;
          ps = 27;
        end
      end
      29: begin pkt_num[23:16] = c; ps = 30; end
      30: begin pkt_num[15:8] = c; ps = 31; end
      31: begin pkt_num[7:0] = c; ps = 32; end
      32: begin pkt_cnt[23:16] = c; ps = 33; end
      33: begin pkt_cnt[15:8] = c; ps = 34; end
      34: begin pkt_cnt[7:0] = c; ps = 35; end
      35: if (remain > 0) remain--; else ps = 36;
      37: begin
        crc_rx[7:0] = c;
        ps = 0;
        d = '0;
        d[8] = (pkt_num == pkt_cnt);
        d[72:49] = pkt_num;
        push_result((crc_rx == ~crc_acc) ? rds_pkg::KIND_RASS_OK : rds_pkg::KIND_RASS_ERR, d);
      end
      38: ps = (len_info == 10 && c == 8) ? 39 : 0;
      39: ps = (c == rds_pkg::AID_HI) ? 40 : 0;
      40: ps = (c == rds_pkg::AID_LO) ? 41 : 0;
      42, 43, 44, 45, 46: begin
        tags[s-42] = c;
        ps = s + 1;
      end
      48: begin
        crc_rx[7:0] = c;
        ps = 0;
        if (crc_rx == ~crc_acc) begin
          if (txt_ok) begin
            d = '0;
            d[12:9]  = tags[0][7:4];
            d[13]    = tags[0][3];
            d[19:14] = {tags[0][2:0], tags[1][7:5]};
            d[25:20] = {tags[1][4:0], tags[2][7]};
            d[31:26] = tags[2][6:1];
            d[37:32] = {tags[2][0], tags[3][7:3]};
            d[43:38] = {tags[3][2:0], tags[4][7:5]};
            d[48:44] = tags[4][4:0];
            push_result(rds_pkg::KIND_RTP, d);
          end
        end else push_result(rds_pkg::KIND_RTP_ERR, '0);
      end
      default: ps = 0;
    endcase
  endtask

  // frame building: payload bytes are escaped and folded into the crc
  task automatic put(input logic [7:0] b);
    build_crc = ccitt(build_crc, b);
    if (b >= rds_pkg::BYTE_ESC) begin
      byte_q.push_back(rds_pkg::BYTE_ESC);
      byte_q.push_back(b - rds_pkg::BYTE_ESC);
    end else byte_q.push_back(b);
  endtask

  task automatic put_crc(input bit bad);
    logic [15:0] v;
    logic [7:0]  hi, lo;
    v = ~build_crc ^ (bad ? 16'(1 << $urandom_range(0, 15)) : 16'h0);
    hi = v[15:8];
    lo = v[7:0];
    put(hi);
    put(lo);
  endtask

  task automatic head(input logic [7:0] li, input logic [7:0] mec);
    byte_q.push_back(rds_pkg::BYTE_START);
    build_crc = 16'hFFFF;
    put($urandom_range(0, 255));
    put($urandom_range(0, 255));
    put($urandom_range(0, 255));
    put(li);
    put(mec);
  endtask

  task automatic build_frame(input frame_kind_t fk, input int size, input bit bad);
    logic [7:0] b;
    logic [23:0] pn;
    case (fk)
      FR_TEXT, FR_SPACES: begin
        head(size + 5 + $urandom_range(0, 3), rds_pkg::MEC_RT);
        put($urandom_range(0, 255));
        put($urandom_range(0, 255));
        put(size + 1);
        put($urandom_range(0, 255));
        for (int i = 0; i < size; i++) begin
          if (fk == FR_SPACES || (i >= size - 3 && $urandom_range(0, 1)))
            b = rds_pkg::BYTE_SPACE;
          else if ($urandom_range(0, 1)) b = $urandom_range(0, 255);
          else b = $urandom_range(8'h21, 8'h7E);
          put(b);
        end
        put_crc(bad);
      end
      FR_RTP: begin
        head(10, rds_pkg::MEC_RTP);
        put(8);
        put(rds_pkg::AID_HI);
        put(rds_pkg::AID_LO);
        put($urandom_range(0, 255));
        for (int i = 0; i < 5; i++) put($urandom_range(0, 255));
        put_crc(bad);
      end
      FR_RASS: begin
        head($urandom_range(0, 255), rds_pkg::MEC_RASS);
        put(9 + size);
        put($urandom_range(0, 255));
        put($urandom_range(0, 255));
        pn = {$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)};
        for (int i = 2; i >= 0; i--) put(pn[i*8 +: 8]);
        if ($urandom_range(0, 1)) pn = {$urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255)};
        for (int i = 2; i >= 0; i--) put(pn[i*8 +: 8]);
        for (int i = 0; i <= size; i++) put($urandom_range(0, 255));
        put_crc(bad);
      end
      FR_BADLEN: begin
        case ($urandom_range(0, 5))
          0: begin head(20, rds_pkg::MEC_RT); put(0); put(0); put(0); end
          1: begin head(8, rds_pkg::MEC_RT); put(0); put(0); put(9); end
          2: begin head(255, rds_pkg::MEC_RT); put(0); put(0); put(66); end
          3: begin head(20, rds_pkg::MEC_RASS); put($urandom_range(0, 8)); end
          4: begin
            head(10, rds_pkg::MEC_RTP); put(8); put(rds_pkg::AID_HI);
            put($urandom_range(0, 255));
          end
          default: head($urandom_range(0, 255), $urandom_range(0, 255));
        endcase
        for (int i = 0; i < size; i++) byte_q.push_back($urandom_range(0, 255));
      end
      default: for (int i = 0; i < size; i++) byte_q.push_back($urandom_range(0, 255));
    endcase
  endtask

  localparam int NROWS = 12;
  frame_row_t directed [NROWS] = '{
    '{FR_RTP, 0, 0},      // rt+ with no text held yields nothing
    '{FR_TEXT, 0, 0},     // empty text
    '{FR_SPACES, 4, 0},   // all spaces keeps first byte
    '{FR_TEXT, 5, 0},
    '{FR_RTP, 0, 0},
    '{FR_RTP, 0, 1},
    '{FR_TEXT, 3, 1},     // text crc error drops held text
    '{FR_RTP, 0, 0},
    '{FR_RASS, 0, 0},
    '{FR_RASS, 2, 1},
    '{FR_TEXT, 64, 0},    // longest text
    '{FR_BADLEN, 2, 0}
  };

  task automatic random_frame();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) build_frame(FR_TEXT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                                  : $urandom_range(0, 8),
                            $urandom_range(0, 5) == 0);
    else if (p < 55) build_frame(FR_RTP, 0, $urandom_range(0, 4) == 0);
    else if (p < 75) build_frame(FR_RASS, $urandom_range(0, 3), $urandom_range(0, 4) == 0);
    else if (p < 85) build_frame(FR_BADLEN, $urandom_range(0, 4), 0);
    else if (p < 92) build_frame(FR_NOISE, $urandom_range(1, 6), 0);
    else begin
      // truncated frame resynced by a raw sync byte
      build_frame(FR_TEXT, $urandom_range(1, 6), 0);
      repeat ($urandom_range(1, 6)) void'(byte_q.pop_back());
      byte_q.push_back(rds_pkg::BYTE_SYNC);
    end
  endtask

  // sender
  initial begin
    int gap, nbytes;
    ps = 0; esc = 0; crc_acc = 16'hFFFF; crc_rx = 0; len_info = 0; remain = 0;
    wr_idx = 0; txt_ok = 0; pkt_num = 0; pkt_cnt = 0;
    foreach (txt_mem[i]) txt_mem[i] = 0;
    foreach (tags[i]) tags[i] = 0;
    foreach (directed[i]) build_frame(directed[i].fk, directed[i].size, directed[i].bad_crc);
    nbytes = 0;
    while (byte_q.size() < 370) random_frame();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    while (byte_q.size() > 0) begin
      if (nbytes % 60 == 0) burst = $urandom_range(0, 2) == 0;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        s_axis_tvalid = 0;
        repeat (gap) @(negedge clk);
      end
      s_axis_tvalid = 1;
      s_axis_tdata = byte_q.pop_front();
      do @(posedge clk); while (!s_axis_tready);
      predict_byte(s_axis_tdata);
      nbytes++;
      @(negedge clk);
    end
    s_axis_tvalid = 0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // receiver
  int fld_lsb [11] = '{0, 8, 9, 13, 14, 20, 26, 32, 38, 44, 49};
  int fld_w   [11] = '{8, 1, 4, 1, 6, 6, 6, 6, 6, 5, 24};

  initial begin
    int stall;
    parse_result_t e;
    logic [79:0] m;
    @(negedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready = 0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected transfer kind %0d data %h", $realtime, m_axis_tuser,
                 m_axis_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.kind !== m_axis_tuser) begin
          $display("%0t kind expected %0d actual %0d", $realtime, e.kind, m_axis_tuser);
          errors++;
        end
        for (int f = 0; f < 11; f++) begin
          m = ((80'h1 << fld_w[f]) - 1) << fld_lsb[f];
          if ((e.data & m) !== (m_axis_tdata & m)) begin
            $display("%0t field %0d expected %h actual %h", $realtime, f,
                     (e.data & m) >> fld_lsb[f], (m_axis_tdata & m) >> fld_lsb[f]);
            errors++;
          end
        end
        if (m_axis_tdata[79:73] !== 7'h0) begin
          $display("%0t padding expected 0 actual %h", $realtime, m_axis_tdata[79:73]);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

endmodule
`default_nettype wire
